FILE: rtl/assert_macros.svh
// assertion helpers for the block's rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/fpr_pkg.sv
package fpr_pkg;

	// default sizing
	localparam int DATA_BYTES_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 8;

	// configuration register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETX_TYPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE  = 2'd2;
	localparam logic [7:0] CRC_POLY_RST  = 8'h07;
	localparam logic [7:0] RETX_TYPE_RST = 8'h01;
	localparam logic [7:0] ACK_TYPE_RST  = 8'h02;

	// result kinds
	localparam logic [1:0] KIND_RX_STATUS = 2'd0;
	localparam logic [1:0] KIND_POP_BYTE  = 2'd1;
	localparam logic [1:0] KIND_POP_EMPTY = 2'd2;

	// reply codes
	localparam logic [1:0] REPLY_NONE     = 2'd0;
	localparam logic [1:0] REPLY_RETX_REQ = 2'd1;
	localparam logic [1:0] REPLY_RESEND   = 2'd2;
	localparam logic [1:0] REPLY_ACK      = 2'd3;

	localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;

	// controller to datapath commands
	typedef struct packed {
		logic load_rx;
		logic pop_start;
		logic pop_empty;
		logic rd_en;
		logic pop_load;
	} fpr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic queue_empty;
		logic idx_last;
	} fpr_sts_t;

	// crc-8, msb first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/fpr_datapath.sv
module fpr_datapath #(
	parameter int DATA_BYTES  = fpr_pkg::DATA_BYTES_DEF,
	parameter int QUEUE_DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic [7:0]                     rx_byte,
	input  fpr_pkg::fpr_cmd_t              cmd,
	output fpr_pkg::fpr_sts_t              sts,
	output logic [1:0]                     kind,
	output logic [1:0]                     reply,
	output logic [7:0]                     packet_byte,
	output logic                           last,
	output logic                           queue_nonempty,
	output logic                           overflow
);
	import fpr_pkg::*;

	localparam int PKT_LEN   = DATA_BYTES + 4;
	localparam int MEM_DEPTH = QUEUE_DEPTH * PKT_LEN;
	localparam int PW = $clog2(PKT_LEN);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [PW-1:0] POS_SIZE  = PW'(0);
	localparam logic [PW-1:0] POS_TYPE  = PW'(1);
	localparam logic [PW-1:0] POS_MSG   = PW'(2);
	localparam logic [PW-1:0] POS_CRC   = PW'(PKT_LEN - 1);
	localparam logic [QW-1:0] QPTR_LAST = QW'(QUEUE_DEPTH - 1);
	localparam logic [AW-1:0] BASE_STEP = AW'(PKT_LEN);

	// configuration registers
	logic [7:0] poly_q, retx_type_q, ack_type_q;

	// parser state
	logic [PW-1:0] pos_q;
	logic [7:0]    hdr_size_q, hdr_type_q, hdr_msg_q;
	logic [7:0]    crc_q;
	logic          all_ff_q;

	// ring pointers and slot base addresses
	logic [QW-1:0] head_q, tail_q;
	logic [AW-1:0] head_base_q, tail_base_q, rd_base_q;
	logic [PW-1:0] idx_q;

	// packet store
	logic [7:0] mem_q [MEM_DEPTH];
	logic [7:0] rd_data_q;

	// output item register
	logic [1:0] kind_q, reply_q;
	logic [7:0] byte_q;
	logic       last_q, nonempty_q, ovf_q;

	logic          is_size, is_type, is_msg, is_crc;
	logic [7:0]    crc_cur, crc_new;
	logic          crc_ok, retx_hit, ack_hit, full, store;
	logic [QW-1:0] tail_nxt, head_nxt, tail_after;
	logic [AW-1:0] tail_base_nxt, head_base_nxt, wr_addr, rd_addr;
	logic [1:0]    rx_reply;
	logic          rx_ovf;

	// byte position decode and crc update
	always_comb begin
		is_size  = (pos_q == POS_SIZE);
		is_type  = (pos_q == POS_TYPE);
		is_msg   = (pos_q == POS_MSG);
		is_crc   = (pos_q == POS_CRC);
		crc_cur  = is_size ? BYTE_ZERO : crc_q;
		crc_new  = crc8_byte(crc_cur, rx_byte, poly_q);
		crc_ok   = (rx_byte == crc_q);
		retx_hit = (hdr_size_q == BYTE_ZERO) && (hdr_type_q == retx_type_q) &&
			(hdr_msg_q == BYTE_ZERO) && all_ff_q;
		ack_hit  = (hdr_size_q == BYTE_ZERO) && (hdr_type_q == ack_type_q) &&
			(hdr_msg_q == BYTE_ZERO) && all_ff_q;
	end

	// ring pointer arithmetic
	always_comb begin
		tail_nxt      = (tail_q == QPTR_LAST) ? '0 : tail_q + QW'(1);
		head_nxt      = (head_q == QPTR_LAST) ? '0 : head_q + QW'(1);
		tail_base_nxt = (tail_q == QPTR_LAST) ? '0 : tail_base_q + BASE_STEP;
		head_base_nxt = (head_q == QPTR_LAST) ? '0 : head_base_q + BASE_STEP;
		full          = (tail_nxt == head_q);
		wr_addr       = tail_base_q + AW'(pos_q);
		rd_addr       = rd_base_q + AW'(idx_q);
	end

	// packet verdict at the crc byte
	always_comb begin
		rx_reply = REPLY_NONE;
		rx_ovf   = 1'b0;
		store    = 1'b0;
		if (is_crc) begin
			priority if (!crc_ok) begin
				rx_reply = REPLY_RETX_REQ;
			end else if (retx_hit) begin
				rx_reply = REPLY_RESEND;
			end else if (ack_hit) begin
				rx_reply = REPLY_NONE;
			end else if (full) begin
				rx_ovf = 1'b1;
			end else begin
				rx_reply = REPLY_ACK;
				store    = 1'b1;
			end
		end
		tail_after = store ? tail_nxt : tail_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q      <= CRC_POLY_RST;
			retx_type_q <= RETX_TYPE_RST;
			ack_type_q  <= ACK_TYPE_RST;
		end else if (cfg_write) begin
			if (cfg_index == REG_CRC_POLY)  poly_q      <= cfg_data;
			if (cfg_index == REG_RETX_TYPE) retx_type_q <= cfg_data;
			if (cfg_index == REG_ACK_TYPE)  ack_type_q  <= cfg_data;
		end
	end

	// parser and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_size_q  <= '0;
			hdr_type_q  <= '0;
			hdr_msg_q   <= '0;
			crc_q       <= '0;
			all_ff_q    <= 1'b1;
			head_q      <= '0;
			tail_q      <= '0;
			head_base_q <= '0;
			tail_base_q <= '0;
			rd_base_q   <= '0;
			idx_q       <= '0;
		end else begin
			if (cmd.load_rx) begin
				if (is_crc) begin
					pos_q    <= '0;
					crc_q    <= '0;
					all_ff_q <= 1'b1;
					if (store) begin
						tail_q      <= tail_nxt;
						tail_base_q <= tail_base_nxt;
					end
				end else begin
					pos_q <= pos_q + PW'(1);
					crc_q <= crc_new;
					if (is_size) begin
						hdr_size_q <= rx_byte;
						all_ff_q   <= 1'b1;
					end else if (is_type) begin
						hdr_type_q <= rx_byte;
					end else if (is_msg) begin
						hdr_msg_q <= rx_byte;
					end else if (rx_byte != BYTE_ALL_ONES) begin
						all_ff_q <= 1'b0;
					end
				end
			end
			if (cmd.pop_start) begin
				rd_base_q   <= head_base_q;
				head_q      <= head_nxt;
				head_base_q <= head_base_nxt;
				idx_q       <= '0;
			end
			if (cmd.pop_load) begin
				idx_q <= idx_q + PW'(1);
			end
		end
	end

	// packet store: received bytes go straight into the free tail slot
	always_ff @(posedge clk) begin
		if (cmd.load_rx) begin
			mem_q[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (cmd.load_rx) begin
			kind_q     <= KIND_RX_STATUS;
			reply_q    <= rx_reply;
			byte_q     <= BYTE_ZERO;
			last_q     <= 1'b1;
			nonempty_q <= (head_q != tail_after);
			ovf_q      <= rx_ovf;
		end else if (cmd.pop_empty) begin
			kind_q     <= KIND_POP_EMPTY;
			reply_q    <= REPLY_NONE;
			byte_q     <= BYTE_ZERO;
			last_q     <= 1'b1;
			nonempty_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (cmd.pop_load) begin
			kind_q     <= KIND_POP_BYTE;
			reply_q    <= REPLY_NONE;
			byte_q     <= rd_data_q;
			last_q     <= (idx_q == POS_CRC);
			nonempty_q <= (head_q != tail_q);
			ovf_q      <= 1'b0;
		end
	end

	assign sts.queue_empty = (head_q == tail_q);
	assign sts.idx_last    = (idx_q == POS_CRC);

	assign kind           = kind_q;
	assign reply          = reply_q;
	assign packet_byte    = byte_q;
	assign last           = last_q;
	assign queue_nonempty = nonempty_q;
	assign overflow       = ovf_q;

endmodule

FILE: rtl/fpr_ctrl.sv
module fpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	output logic              out_valid,
	input  logic              out_stall,
	input  fpr_pkg::fpr_sts_t sts,
	output fpr_pkg::fpr_cmd_t cmd
);
	import fpr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_POP_WR
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free, accept;

	// command decode
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = !((state_q == ST_IDLE) && out_free);
		accept   = in_valid && !in_stall;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!action) begin
						cmd.load_rx = 1'b1;
					end else if (sts.queue_empty) begin
						cmd.pop_empty = 1'b1;
					end else begin
						cmd.pop_start = 1'b1;
					end
				end
			end
			ST_POP_RD: begin
				cmd.rd_en = 1'b1;
			end
			ST_POP_WR: begin
				cmd.pop_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_rx || cmd.pop_empty || cmd.pop_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.pop_start) state_q <= ST_POP_RD;
				end
				ST_POP_RD: begin
					state_q <= ST_POP_WR;
				end
				ST_POP_WR: begin
					if (cmd.pop_load) begin
						state_q <= sts.idx_last ? ST_IDLE : ST_POP_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/framed_packet_receiver_with_ack_queue.sv
// Framed packet receiver with a packet queue.
// Input channel (in_valid/in_stall) carries one item per handshake: action 0 feeds
// rx_byte to the parser, action 1 pops the oldest queued packet.
// Packets are DATA_BYTES + 4 bytes: size, type, message type, payload, crc-8.
// Output channel (out_valid/out_stall) carries result items from one output register.
// Received byte: one status item, valid the cycle after the accept; with the output
// free a new byte is taken every cycle. The crc-8 of each byte is done in that cycle.
// Pop on an empty queue: one item, valid the cycle after the accept.
// Pop: DATA_BYTES + 4 byte items, each a store read (ST_POP_RD), then an output load
// (ST_POP_WR) that waits while the output is stalled; the first read follows the accept.
// The store read is not overlapped with the output load, and the input is stalled
// until the last byte item has been loaded.
// When the receiver stalls, the output item holds and no new item is accepted.
// Reset clears the parser, the queue pointers and the configuration registers; the
// packet store is not cleared, as every slot is written before it is read.
// Configuration: cfg_write, cfg_index, cfg_data; writes take effect at the next edge.
module framed_packet_receiver_with_ack_queue #(
	parameter int DATA_BYTES  = fpr_pkg::DATA_BYTES_DEF,
	parameter int QUEUE_DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [1:0]                    reply,
	output logic [7:0]                    packet_byte,
	output logic                          last,
	output logic                          queue_nonempty,
	output logic                          overflow
);
	import fpr_pkg::*;

`include "assert_macros.svh"

	fpr_cmd_t cmd;
	fpr_sts_t sts;
	logic     last_load;

	// sequencer
	fpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// parser, crc, queue and output register
	fpr_datapath #(
		.DATA_BYTES  (DATA_BYTES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.reply          (reply),
		.packet_byte    (packet_byte),
		.last           (last),
		.queue_nonempty (queue_nonempty),
		.overflow       (overflow)
	);

	// final byte of a pop goes into the output register
	assign last_load = cmd.pop_load && sts.idx_last;

	// checks
	`ASSERT_ALWAYS(a_cmd_onehot, clk, arst_n, $onehot0(cmd))
	`ASSERT_NEXT(a_pop_blocks_input, clk, arst_n, cmd.pop_start, in_stall)
	`ASSERT_NEXT(a_pop_last_byte, clk, arst_n, last_load, out_valid && last && (kind == KIND_POP_BYTE))
	`ASSERT_ALWAYS(a_empty_pop_item, clk, arst_n, !(out_valid && (kind == KIND_POP_EMPTY) && queue_nonempty))

endmodule
